@@ design/wide_integer_divider_defines.svh @@
// Assertion macros used by the divider controller.
`ifndef WIDE_INTEGER_DIVIDER_DEFINES_SVH
`define WIDE_INTEGER_DIVIDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check on clk, disabled while rst_n is low.
`define WID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wid: check failed");
// Same check with a message of the caller's choosing.
`define WID_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define WID_ASSERT(lbl, prop)
`define WID_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

@@ design/wid_pkg.sv @@
// Shared types and constants for the wide integer divider.
`default_nettype none

package wid_pkg;

    // Width of one half of an operand on the stream and of a full operand
    localparam int HALF_W = 64;
    localparam int FULL_W = 128;

    // Default operand width
    localparam int DEF_OPERAND_W = 128;

    // Divide mode carried in s_axis_tuser
    localparam logic ACTION_UNSIGNED = 1'b0;
    localparam logic ACTION_SIGNED   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // take a new beat, negate operands as needed
        logic step;     // retire one quotient bit
        logic finish;   // sign fixup into the output register
    } wid_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_step; // current step retires the last quotient bit
    } wid_status_t;

endpackage

`default_nettype wire

@@ design/wid_datapath.sv @@
// Datapath of the divider: operand magnitudes, restoring step, sign fixup.
`default_nettype none

module wid_datapath
    import wid_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_W
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire wid_cmd_t                 cmd,
    output wid_status_t                   status,
    input  wire logic                     action_signed,
    input  wire logic [OPERAND_WIDTH-1:0] dividend_in,
    input  wire logic [OPERAND_WIDTH-1:0] divisor_in,
    output logic [FULL_W-1:0]             quotient,
    output logic [FULL_W-1:0]             remainder,
    output logic                          zero_divisor
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    // Working registers: n_reg shifts dividend bits out and quotient bits in
    logic [W-1:0]      n_reg, n_next;
    logic [W-1:0]      d_reg, d_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic              zero_reg, zero_next;
    logic [FULL_W-1:0] quo_out_reg, quo_out_next;
    logic [FULL_W-1:0] rem_out_reg, rem_out_next;
    logic              zero_out_reg, zero_out_next;

    logic              neg_n, neg_d;
    logic [W:0]        rem_sh;
    logic [W+1:0]      diff;
    logic              ge;
    logic [W-1:0]      q_sel, r_sel, q_fix, r_fix;

    // Operand signs at load
    assign neg_n = (action_signed == ACTION_SIGNED) && dividend_in[W-1];
    assign neg_d = (action_signed == ACTION_SIGNED) && divisor_in[W-1];

    // One restoring step: shift in next dividend bit, trial subtract
    assign rem_sh = {rem_reg, n_reg[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, d_reg};
    assign ge     = !diff[W+1];

    // Result selection and sign fixup
    assign q_sel = zero_reg ? {W{1'b1}} : n_reg;
    assign r_sel = zero_reg ? {W{1'b0}} : rem_reg;
    assign q_fix = neg_q_reg ? ({W{1'b0}} - q_sel) : q_sel;
    assign r_fix = neg_r_reg ? ({W{1'b0}} - r_sel) : r_sel;

    assign status.last_step = (count_reg == CW'(W - 1));

    // Next-state logic
    always_comb
    begin
        n_next        = n_reg;
        d_next        = d_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        neg_q_next    = neg_q_reg;
        neg_r_next    = neg_r_reg;
        zero_next     = zero_reg;
        quo_out_next  = quo_out_reg;
        rem_out_next  = rem_out_reg;
        zero_out_next = zero_out_reg;
        if (cmd.load)
        begin
            n_next     = neg_n ? ({W{1'b0}} - dividend_in) : dividend_in;
            d_next     = neg_d ? ({W{1'b0}} - divisor_in) : divisor_in;
            rem_next   = '0;
            count_next = '0;
            neg_q_next = neg_n ^ neg_d;
            neg_r_next = neg_n;
            zero_next  = (divisor_in == {W{1'b0}});
        end
        if (cmd.step)
        begin
            rem_next   = ge ? diff[W-1:0] : rem_sh[W-1:0];
            n_next     = {n_reg[W-2:0], ge};
            count_next = count_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            quo_out_next  = FULL_W'(q_fix);
            rem_out_next  = FULL_W'(r_fix);
            zero_out_next = zero_reg;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        rem_reg      <= rem_next;
        neg_q_reg    <= neg_q_next;
        neg_r_reg    <= neg_r_next;
        zero_reg     <= zero_next;
        quo_out_reg  <= quo_out_next;
        rem_out_reg  <= rem_out_next;
        zero_out_reg <= zero_out_next;
    end

    assign quotient     = quo_out_reg;
    assign remainder    = rem_out_reg;
    assign zero_divisor = zero_out_reg;

endmodule

`default_nettype wire

@@ design/wid_ctrl.sv @@
// Controller of the divider: sequencing and output beat handshake.
`default_nettype none

`include "wide_integer_divider_defines.svh"

module wid_ctrl
    import wid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output wid_cmd_t         cmd,
    input  wire wid_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIX  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Commands
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = in_valid && in_ready;
    assign cmd.step   = (state_reg == S_DIV);
    assign cmd.finish = (state_reg == S_FIX) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    // State and output-valid next values
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.last_step)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `WID_ASSERT(a_load_starts, cmd.load |=> (state_reg == S_DIV))
    `WID_ASSERT(a_last_to_fix, (cmd.step && status.last_step) |=> (state_reg == S_FIX))
    `WID_ASSERT_MSG(a_finish_shows, cmd.finish |=> out_valid_reg, "wid: result not shown")
    `WID_ASSERT_MSG(a_no_overwrite,
        ((state_reg == S_FIX) && out_valid_reg && !out_ready) |=> (state_reg == S_FIX),
        "wid: pending result overwritten")

endmodule

`default_nettype wire

@@ design/wide_integer_divider.sv @@
// Top level of the wide integer divider.
`default_nettype none

// Radix-2 restoring divider for OPERAND_WIDTH-bit integers (8 to 128,
// default 128), unsigned or two's complement. Each input beat is accepted
// only while the unit is idle. The beat is captured with its operand
// magnitudes, then one quotient bit is retired per step through the single
// shared subtract-and-compare, then the sign fixup goes into the output
// register once it is free. The output register holds one finished result,
// so the next beat is taken while it waits. Input bits above OPERAND_WIDTH
// are ignored, results are zero extended. A zero divisor sets tuser with
// remainder 0 and quotient all ones (1 for a negative dividend in signed
// mode).
module wide_integer_divider
    import wid_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_W
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // dividend_hi, dividend_lo, divisor_hi, divisor_lo (64 bits each)
    input  wire logic [4*HALF_W-1:0] s_axis_tdata,
    // action
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // quotient_hi, quotient_lo, remainder_hi, remainder_lo (64 bits each)
    output logic [4*HALF_W-1:0]      m_axis_tdata,
    // zero_divisor
    output logic                     m_axis_tuser
);

    wid_cmd_t           cmd;
    wid_status_t        status;
    logic [FULL_W-1:0]  dividend_full, divisor_full;
    logic [FULL_W-1:0]  quotient, remainder;

    // Rebuild full operands from their halves
    assign dividend_full = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[2*HALF_W-1:HALF_W]};
    assign divisor_full  = {s_axis_tdata[3*HALF_W-1:2*HALF_W],
                            s_axis_tdata[4*HALF_W-1:3*HALF_W]};

    wid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    wid_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action_signed (s_axis_tuser),
        .dividend_in   (dividend_full[OPERAND_WIDTH-1:0]),
        .divisor_in    (divisor_full[OPERAND_WIDTH-1:0]),
        .quotient      (quotient),
        .remainder     (remainder),
        .zero_divisor  (m_axis_tuser)
    );

    // Split results into halves, high half first
    assign m_axis_tdata = {remainder[HALF_W-1:0], remainder[FULL_W-1:HALF_W],
                           quotient[HALF_W-1:0], quotient[FULL_W-1:HALF_W]};

endmodule

`default_nettype wire

@@ test/wid_checker.sv @@
// Checker for the wide integer divider: predicts every result and compares it.
`timescale 1ns / 100ps

module wid_checker
    import wid_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // dividend_hi, dividend_lo, divisor_hi, divisor_lo (64 bits each)
    input  logic [4*HALF_W-1:0] s_axis_tdata,
    // action
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // quotient_hi, quotient_lo, remainder_hi, remainder_lo (64 bits each)
    input  logic [4*HALF_W-1:0] m_axis_tdata,
    // zero_divisor
    input  logic                m_axis_tuser,
    output int                  error_count,
    output int                  pending_count
);

    // Operand width clamped to 8 to FULL_W for the prediction
    localparam int EFF_W = (OPERAND_WIDTH < 8) ? 8 :
                           (OPERAND_WIDTH > FULL_W) ? FULL_W : OPERAND_WIDTH;
    localparam logic [FULL_W-1:0] WIDTH_MASK = {FULL_W{1'b1}} >> (FULL_W - EFF_W);

    typedef struct packed {
        logic [HALF_W-1:0] quo_hi;
        logic [HALF_W-1:0] quo_lo;
        logic [HALF_W-1:0] rem_hi;
        logic [HALF_W-1:0] rem_lo;
        logic              by_zero;
    } quot_rem_t;

    quot_rem_t quot_rem_q[$];

    // Quotient and remainder of one input beat
    function automatic quot_rem_t divide_predict(input logic act,
                                                 input logic [4*HALF_W-1:0] data);
        logic [FULL_W-1:0] num;
        logic [FULL_W-1:0] den;
        logic [FULL_W-1:0] quo;
        logic [FULL_W-1:0] rem;
        logic              neg_num;
        logic              neg_den;
        logic              by_zero;
        quot_rem_t         res;
        num = {data[HALF_W-1:0], data[2*HALF_W-1:HALF_W]} & WIDTH_MASK;
        den = {data[3*HALF_W-1:2*HALF_W], data[4*HALF_W-1:3*HALF_W]} & WIDTH_MASK;
        neg_num = 1'b0;
        neg_den = 1'b0;
        // signed mode works on magnitudes
        if (act == ACTION_SIGNED)
        begin
            neg_num = num[EFF_W-1];
            neg_den = den[EFF_W-1];
            if (neg_num)
                num = (-num) & WIDTH_MASK;
            if (neg_den)
                den = (-den) & WIDTH_MASK;
        end
        by_zero = (den == '0);
        if (by_zero)
        begin
            quo = WIDTH_MASK;
            rem = '0;
        end
        else
        begin
            quo = num / den;
            rem = num % den;
        end
        // sign fixup: quotient by sign mismatch, remainder follows dividend
        if (act == ACTION_SIGNED)
        begin
            if (neg_num != neg_den)
                quo = (-quo) & WIDTH_MASK;
            if (neg_num)
                rem = (-rem) & WIDTH_MASK;
        end
        res.quo_hi  = quo[FULL_W-1:HALF_W];
        res.quo_lo  = quo[HALF_W-1:0];
        res.rem_hi  = rem[FULL_W-1:HALF_W];
        res.rem_lo  = rem[HALF_W-1:0];
        res.by_zero = by_zero;
        return res;
    endfunction

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

    // Watch both channels on the rising edge
    always @(posedge clk)
    begin
        quot_rem_t want;
        if (rst_n)
        begin
            // result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (quot_rem_q.size() == 0)
                begin
                    $error("result beat with no pending item: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = quot_rem_q.pop_front();
                    if (m_axis_tdata[HALF_W-1:0] !== want.quo_hi)
                    begin
                        $error("quotient_hi: expected %h, got %h",
                               want.quo_hi, m_axis_tdata[HALF_W-1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[2*HALF_W-1:HALF_W] !== want.quo_lo)
                    begin
                        $error("quotient_lo: expected %h, got %h",
                               want.quo_lo, m_axis_tdata[2*HALF_W-1:HALF_W]);
                        error_count++;
                    end
                    if (m_axis_tdata[3*HALF_W-1:2*HALF_W] !== want.rem_hi)
                    begin
                        $error("remainder_hi: expected %h, got %h",
                               want.rem_hi, m_axis_tdata[3*HALF_W-1:2*HALF_W]);
                        error_count++;
                    end
                    if (m_axis_tdata[4*HALF_W-1:3*HALF_W] !== want.rem_lo)
                    begin
                        $error("remainder_lo: expected %h, got %h",
                               want.rem_lo, m_axis_tdata[4*HALF_W-1:3*HALF_W]);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.by_zero)
                    begin
                        $error("zero_divisor: expected %b, got %b",
                               want.by_zero, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            // accepted input beat
            if (s_axis_tvalid && s_axis_tready)
                quot_rem_q.push_back(divide_predict(s_axis_tuser, s_axis_tdata));
            pending_count = quot_rem_q.size();
        end
    end

endmodule

@@ test/wide_integer_divider_tb.sv @@
// Testbench top for the wide integer divider: stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module wide_integer_divider_tb
    import wid_pkg::*;
();

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DRAIN_CYCLES  = 140;
    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_AT_ITEM  = 150;

    localparam logic [FULL_W-1:0] MOST_NEG = {1'b1, {(FULL_W-1){1'b0}}};
    localparam logic [FULL_W-1:0] MOST_POS = {1'b0, {(FULL_W-1){1'b1}}};
    localparam logic [FULL_W-1:0] ALL_ONES = {FULL_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [4*HALF_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [4*HALF_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    int error_count;
    int pending_count;
    int cycle_count;
    int burst_left;
    bit hold_go;

    wide_integer_divider uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wid_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("wide_integer_divider verification failed");
        $finish;
    end

    // Result side: random stall modes, plus one long hold-off on request
    initial
    begin
        int  run_len;
        int  mode;
        int  hold_left;
        bit  hold_taken;
        m_axis_tready = 1'b0;
        run_len       = 0;
        mode          = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (run_len == 0)
            begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(1, 40);
            end
            run_len--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0, 1:    m_axis_tready <= 1'b1;
                    2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Drive one beat at the falling edge and wait for it to be taken
    task automatic send_beat(input logic act, input logic [FULL_W-1:0] num,
                             input logic [FULL_W-1:0] den);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {den[HALF_W-1:0], den[FULL_W-1:HALF_W],
                          num[HALF_W-1:0], num[FULL_W-1:HALF_W]};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Bursts of beats with idle gaps between them
    task automatic offer(input logic act, input logic [FULL_W-1:0] num,
                         input logic [FULL_W-1:0] den);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        send_beat(act, num, den);
    endtask

    // Random operand: full width, short positive, short negative, near a power of two
    function automatic logic [FULL_W-1:0] rand_operand();
        logic [FULL_W-1:0] v;
        int                sh;
        v  = {$urandom, $urandom, $urandom, $urandom};
        sh = $urandom_range(0, FULL_W - 1);
        case ($urandom_range(0, 4))
            0:       return v;
            1:       return v >> sh;
            2:       return ~(v >> sh);
            3:       return (FULL_W'(1) << sh) - FULL_W'($urandom_range(0, 1));
            default: return v >> $urandom_range(HALF_W, FULL_W - 1);
        endcase
    endfunction

    // Stimulus and verdict
    initial
    begin
        logic              act;
        logic [FULL_W-1:0] num;
        logic [FULL_W-1:0] den;
        int                sel;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACTION_UNSIGNED;
        burst_left    = 0;
        hold_go       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero divisor, most negative cases
        send_beat(ACTION_UNSIGNED, '0, FULL_W'(1));
        send_beat(ACTION_UNSIGNED, FULL_W'(1), '0);
        send_beat(ACTION_UNSIGNED, ALL_ONES, FULL_W'(1));
        send_beat(ACTION_UNSIGNED, ALL_ONES, ALL_ONES);
        send_beat(ACTION_UNSIGNED, ALL_ONES, '0);
        send_beat(ACTION_UNSIGNED, '0, '0);
        send_beat(ACTION_UNSIGNED, FULL_W'(1), ALL_ONES);
        send_beat(ACTION_UNSIGNED, MOST_NEG, FULL_W'(1) << HALF_W);
        send_beat(ACTION_UNSIGNED, {{HALF_W{1'b0}}, {HALF_W{1'b1}}}, FULL_W'(3));
        send_beat(ACTION_UNSIGNED, ALL_ONES, MOST_NEG);
        send_beat(ACTION_SIGNED, MOST_NEG, ALL_ONES);
        send_beat(ACTION_SIGNED, MOST_NEG, FULL_W'(1));
        send_beat(ACTION_SIGNED, ~FULL_W'(6), FULL_W'(2));
        send_beat(ACTION_SIGNED, FULL_W'(7), ~FULL_W'(1));
        send_beat(ACTION_SIGNED, ~FULL_W'(6), ~FULL_W'(1));
        send_beat(ACTION_SIGNED, ALL_ONES, '0);
        send_beat(ACTION_SIGNED, FULL_W'(5), '0);
        send_beat(ACTION_SIGNED, MOST_NEG, '0);
        send_beat(ACTION_SIGNED, MOST_POS, MOST_NEG);
        send_beat(ACTION_SIGNED, MOST_NEG, MOST_NEG);
        send_beat(ACTION_SIGNED, '0, ALL_ONES);
        send_beat(ACTION_SIGNED, ALL_ONES, FULL_W'(1));

        // random part
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == HOLD_AT_ITEM)
                hold_go = 1'b1;
            act = 1'($urandom_range(0, 1));
            num = rand_operand();
            den = rand_operand();
            sel = $urandom_range(0, 39);
            if (sel == 0)
                den = '0;
            else if (sel == 1)
            begin
                num = MOST_NEG;
                den = ALL_ONES;
            end
            else if (sel == 2)
                den = FULL_W'(1);
            offer(act, num, den);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("wide_integer_divider verification clean");
        else
            $display("wide_integer_divider verification failed");
        $finish;
    end

endmodule
